/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL.
// They compile to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// prop must hold at every clock edge outside reset
`define ASSERT_HOLDS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// cond must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_HOLDS(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

/* rtl/mexp_pkg.sv */
package mexp_pkg;

    localparam int MEXP_WIDTH = 64;   // default operand width
    localparam int DATA_W     = 64;   // width of base, result and registers
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS  = 1'b1;

    localparam logic [DATA_W-1:0] EXPONENT_RESET = 64'd65537;
    localparam logic [DATA_W-1:0] MODULUS_RESET  = 64'd2;

    // status of one modular multiplier
    typedef struct packed {
        logic busy;
        logic done;   // one-cycle pulse, product valid
    } t_mul_stat;

endpackage

/* rtl/modular_exponentiation_core.sv */
// Sequence: an input beat is reduced mod m, then both multipliers run once per
//   exponent bit before the result beat; a zero modulus goes straight to finish.
// Flow control: one beat at a time; the next input is taken no earlier than the
//   cycle after the result register loads. The run time is set by the bit-serial
//   modular multipliers, which work through each exponent bit in turn.
// Reset: synchronous, active low; exponent returns to 65537, modulus to 2, and
//   the control and output valid flags clear.
`include "assert_macros.svh"

module modular_exponentiation_core
    import mexp_pkg::*;
#(
    parameter int WIDTH = MEXP_WIDTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    // configuration writes
    input  logic                 i_cfg_wen,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]    i_cfg_data,

    // input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [DATA_W-1:0]    s_axis_tdata,   // [63:0] base

    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [DATA_W-1:0]    m_axis_tdata    // [63:0] power_mod
);

    localparam int CW = $clog2(WIDTH);

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;  // waiting for a base
    localparam logic [1:0] S_RED  = 2'd1;  // base mod m, via 1 * base
    localparam logic [1:0] S_MUL  = 2'd2;  // one exponent bit: acc*x and x*x together
    localparam logic [1:0] S_FIN  = 2'd3;  // hand result to output register

    // config registers
    logic [DATA_W-1:0] r_exponent;
    logic [DATA_W-1:0] r_modulus;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exponent <= EXPONENT_RESET;
            r_modulus  <= MODULUS_RESET;
        end else if (i_cfg_wen) begin
            unique case (i_cfg_index)
                CFG_EXPONENT: r_exponent <= i_cfg_data;
                CFG_MODULUS:  r_modulus  <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    // only the low WIDTH bits take part
    logic [WIDTH-1:0] w_m;
    logic [WIDTH-1:0] w_one_m;   // 1 mod m
    assign w_m     = r_modulus[WIDTH-1:0];
    assign w_one_m = {{(WIDTH-1){1'b0}}, (w_m != WIDTH'(1))};

    logic [1:0]       r_state;
    logic [WIDTH-1:0] r_acc;     // running result
    logic [WIDTH-1:0] r_x;       // running square (base during reduction)
    logic [WIDTH-1:0] r_e;       // exponent, shifted right one bit per step
    logic [CW-1:0]    r_cnt;     // exponent bit index
    logic             r_start_a;
    logic             r_start_b;
    logic             r_out_valid;
    logic [DATA_W-1:0] r_out_data;

    logic [WIDTH-1:0] w_a_a;
    logic [WIDTH-1:0] w_prod_a;
    logic [WIDTH-1:0] w_prod_b;
    t_mul_stat        w_stat_a;
    t_mul_stat        w_stat_b;
    logic             w_accept;
    logic             w_load_out;

    // unit A: reduction first (1 * base), then acc * x
    assign w_a_a = (r_state == S_RED) ? w_one_m : r_acc;

    mexp_mulmod #(.WIDTH(WIDTH)) u_mul_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start_a),
        .i_a     (w_a_a),
        .i_b     (r_x),
        .i_m     (w_m),
        .o_prod  (w_prod_a),
        .o_stat  (w_stat_a)
    );

    // unit B: x * x
    mexp_mulmod #(.WIDTH(WIDTH)) u_mul_sq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start_b),
        .i_a     (r_x),
        .i_b     (r_x),
        .i_m     (w_m),
        .o_prod  (w_prod_b),
        .o_stat  (w_stat_b)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_load_out    = (r_state == S_FIN) && (!r_out_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_start_a <= 1'b0;
            r_start_b <= 1'b0;
            r_cnt     <= '0;
        end else begin
            r_start_a <= 1'b0;
            r_start_b <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (w_m == '0) begin
                            r_state <= S_FIN;       // no valid modulus: answer 0
                        end else begin
                            r_start_a <= 1'b1;
                            r_state   <= S_RED;
                        end
                    end
                end
                S_RED: begin
                    if (w_stat_a.done) begin
                        r_start_a <= 1'b1;
                        r_start_b <= 1'b1;
                        r_cnt     <= '0;
                        r_state   <= S_MUL;
                    end
                end
                S_MUL: begin
                    // both units share the same latency
                    if (w_stat_a.done) begin
                        if (r_cnt == CW'(WIDTH - 1)) begin
                            r_state <= S_FIN;
                        end else begin
                            r_cnt     <= r_cnt + CW'(1);
                            r_start_a <= 1'b1;
                            r_start_b <= 1'b1;
                        end
                    end
                end
                S_FIN: begin
                    if (w_load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x   <= s_axis_tdata[WIDTH-1:0];
            r_acc <= (w_m == '0) ? '0 : w_one_m;
        end
        if (r_state == S_RED && w_stat_a.done) begin
            r_x <= w_prod_a;
            r_e <= r_exponent[WIDTH-1:0];
        end
        if (r_state == S_MUL && w_stat_a.done) begin
            if (r_e[0]) begin
                r_acc <= w_prod_a;
            end
            r_x <= w_prod_b;
            r_e <= {1'b0, r_e[WIDTH-1:1]};
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_data <= DATA_W'(r_acc);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // checks
    `ASSERT_HOLDS(a_units_lockstep, i_clk, i_rst_n,
        (r_state == S_MUL) |-> (w_stat_a.done == w_stat_b.done), "multipliers out of step")
    `ASSERT_NEVER(a_idle_units_quiet, i_clk, i_rst_n,
        (r_state == S_IDLE) && (w_stat_a.busy || w_stat_b.busy), "multiplier busy while idle")
    `ASSERT_HOLDS(a_out_from_fin, i_clk, i_rst_n,
        $rose(m_axis_tvalid) |-> $past(r_state == S_FIN), "result beat without finish")
    `ASSERT_NEVER(a_start_while_busy, i_clk, i_rst_n,
        r_start_a && w_stat_a.busy, "multiplier restarted mid-run")

endmodule

/* rtl/mexp_mulmod.sv */
// Bit-serial modular multiplier: r = a * b mod m, b scanned from the top bit.
// Each bit of b takes a doubling step, then a conditional add of a.
module mexp_mulmod
    import mexp_pkg::*;
#(
    parameter int WIDTH = MEXP_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_a,     // must be below i_m
    input  logic [WIDTH-1:0] i_b,
    input  logic [WIDTH-1:0] i_m,     // nonzero, held for the whole run
    output logic [WIDTH-1:0] o_prod,
    output t_mul_stat        o_stat
);

    localparam int CW = $clog2(WIDTH);

    // (x + y) mod m for x, y < m
    function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] x,
                                                 input logic [WIDTH-1:0] y,
                                                 input logic [WIDTH-1:0] m);
        logic [WIDTH:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, m}) begin
            s = s - {1'b0, m};
        end
        return s[WIDTH-1:0];
    endfunction

    logic [WIDTH-1:0] r_r;
    logic [WIDTH-1:0] r_a;
    logic [WIDTH-1:0] r_b;
    logic [CW-1:0]    r_cnt;
    logic             r_ph;
    logic             r_busy;
    logic             r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_ph   <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_ph   <= 1'b0;
                r_cnt  <= CW'(WIDTH - 1);
            end else if (r_busy) begin
                r_ph <= ~r_ph;
                if (r_ph) begin
                    if (r_cnt == '0) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end else begin
                        r_cnt <= r_cnt - CW'(1);
                    end
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_r <= '0;
            r_a <= i_a;
            r_b <= i_b;
        end else if (r_busy) begin
            if (!r_ph) begin
                r_r <= add_mod(r_r, r_r, i_m);
            end else begin
                if (r_b[WIDTH-1]) begin
                    r_r <= add_mod(r_r, r_a, i_m);
                end
                r_b <= {r_b[WIDTH-2:0], 1'b0};
            end
        end
    end

    assign o_prod      = r_r;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

/* dv/modular_exponentiation_core_tb.sv */
`timescale 1ns / 100ps

module modular_exponentiation_core_tb
    import mexp_pkg::*;
();

    // Run length: about 100 bases. Add one long receiver hold-off plus the random
    // gaps on both sides; the cycle limit allows about five times that.
    localparam int CYCLE_LIMIT    = 5_000_000;
    localparam int RX_HOLD_CYCLES = 30_000;   // long enough that the input backs up
    localparam int IDLE_SETTLE    = 16;       // gap before a key change
    localparam int END_SETTLE     = 200;      // watch for stray results at the end
    localparam int GROUP_SIZE     = 8;
    localparam int NUM_GROUPS     = 10;

    // Operand mask: the core only looks at the low MEXP_WIDTH bits.
    localparam logic [DATA_W-1:0] OP_MASK = {DATA_W{1'b1}} >> (DATA_W - MEXP_WIDTH);

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_wen     = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index   = CFG_EXPONENT;
    logic [DATA_W-1:0]    i_cfg_data    = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [DATA_W-1:0]    s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [DATA_W-1:0]    m_axis_tdata;

    // Shadow of the key registers, updated on each write.
    logic [DATA_W-1:0] key_exponent = EXPONENT_RESET;
    logic [DATA_W-1:0] key_modulus  = MODULUS_RESET;

    logic [DATA_W-1:0] pending_bases[$];     // bases waiting for the driver
    logic [DATA_W-1:0] expected_powers[$];   // predicted results, oldest first

    logic in_beat = 1'b0;      // input beat taken at the last rising edge
    logic rx_hold = 1'b0;      // long receiver hold-off in progress
    logic pressure_go = 1'b0;  // kicks off the hold-off process

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int error_count     = 0;
    int bases_sent      = 0;
    int results_checked = 0;
    int key_writes      = 0;
    int cycle_count     = 0;

    modular_exponentiation_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),    // [63:0] base
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)     // [63:0] power_mod
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor: plain square-and-multiply using full-width products,
    // independent of the core's bit-serial shift-and-add scheme.
    // ------------------------------------------------------------------
    function automatic logic [DATA_W-1:0] mod_mul(input logic [DATA_W-1:0] a,
                                                  input logic [DATA_W-1:0] b,
                                                  input logic [DATA_W-1:0] m);
        logic [2*DATA_W-1:0] prod;
        prod = {{DATA_W{1'b0}}, a} * {{DATA_W{1'b0}}, b};
        prod = prod % {{DATA_W{1'b0}}, m};
        return prod[DATA_W-1:0];
    endfunction

    function automatic logic [DATA_W-1:0] mod_power(input logic [DATA_W-1:0] base);
        logic [DATA_W-1:0] m;
        logic [DATA_W-1:0] e;
        logic [DATA_W-1:0] sq;
        logic [DATA_W-1:0] acc;
        m = key_modulus & OP_MASK;
        e = key_exponent & OP_MASK;
        // no valid modulus: the core answers zero
        if (m == '0)
            return '0;
        sq  = (base & OP_MASK) % m;
        acc = (m == DATA_W'(1)) ? '0 : DATA_W'(1);   // x^0 = 1 mod m, 0 for m = 1
        for (int i = 0; i < MEXP_WIDTH; i++) begin
            if (e[i])
                acc = mod_mul(acc, sq, m);
            sq = mod_mul(sq, sq, m);
        end
        return acc;
    endfunction

    function automatic logic [DATA_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // queue one base for the driver
    task automatic add_base(input logic [DATA_W-1:0] b);
        pending_bases = {pending_bases, b};
    endtask

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] want,
                                   input logic [DATA_W-1:0] got);
        $display("[%0t] MISMATCH %s: expected %h, got %h", $time, what, want, got);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // Input driver: changes on the falling edge, holds a beat until taken.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_beat) begin
            if (in_beat)
                void'(pending_bases.pop_front());
            if (pending_bases.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pending_bases[0];
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result side ready: random stalls, forced low during the long hold-off.
    always @(negedge i_clk) begin
        if (!i_rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    // Long hold-off, counted here so the sender keeps offering meanwhile.
    initial begin
        wait (pressure_go);
        @(negedge i_clk);
        rx_hold <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(negedge i_clk);
        rx_hold <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Monitor: predict on each input beat, check each result beat in order.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        in_beat <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_powers = {expected_powers, mod_power(s_axis_tdata)};
                bases_sent++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_powers.size() == 0) begin
                    report_mismatch("result with none pending", '0, m_axis_tdata);
                end else begin
                    logic [DATA_W-1:0] want;
                    want = expected_powers.pop_front();
                    if (m_axis_tdata !== want)
                        report_mismatch("power_mod", want, m_axis_tdata);
                    results_checked++;
                end
            end
        end
    end

    // Hard stop if the core hangs.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[%0t] timeout after %0d cycles", $time, cycle_count);
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic write_key_reg(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_wen   <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_wen   <= 1'b0;
        if (idx == CFG_EXPONENT)
            key_exponent = val;
        else
            key_modulus = val;
        key_writes++;
    endtask

    task automatic set_key(input logic [DATA_W-1:0] e, input logic [DATA_W-1:0] m);
        write_key_reg(CFG_EXPONENT, e);
        write_key_reg(CFG_MODULUS, m);
        @(posedge i_clk);
    endtask

    // Only safe to rewrite the key once nothing is queued, offered or owed.
    task automatic wait_idle();
        do
            @(posedge i_clk);
        while (pending_bases.size() != 0 || s_axis_tvalid || expected_powers.size() != 0);
        repeat (IDLE_SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [DATA_W-1:0] pick_modulus();
        case ($urandom_range(11))
            0:       return '0;                       // no valid modulus
            1:       return DATA_W'(1);               // everything maps to 0
            2:       return '1;
            3:       return DATA_W'($urandom_range(2, 255));
            4:       return {32'd0, $urandom};
            5:       return {1'b1, 63'(rand64())};    // top bit set
            default: return rand64();
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_exponent();
        case ($urandom_range(9))
            0:       return '0;
            1:       return DATA_W'(1);
            2:       return '1;
            3:       return EXPONENT_RESET;
            4:       return DATA_W'($urandom_range(2, 64));
            default: return rand64();
        endcase
    endfunction

    // Bases near the modulus exercise the initial reduction.
    function automatic logic [DATA_W-1:0] pick_base();
        case ($urandom_range(11))
            0:       return '0;
            1:       return DATA_W'(1);
            2:       return '1;
            3:       return key_modulus - DATA_W'(1);
            4:       return key_modulus;
            5:       return key_modulus + DATA_W'(1);
            default: return rand64();
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        logic [DATA_W-1:0] m_pick;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // sender idles 30%, receiver 52% for directed and the first random stretch
        send_idle_pct = 30;
        recv_idle_pct = 52;

        // Reset key: exponent 65537, modulus 2.
        add_base('0);
        add_base(DATA_W'(1));
        add_base('1);
        add_base(DATA_W'(3));
        wait_idle();

        // Largest exponent and modulus; all-ones base reduces to zero.
        set_key('1, '1);
        add_base('0);
        add_base(DATA_W'(1));
        add_base('1);
        add_base({{(DATA_W-1){1'b1}}, 1'b0});
        add_base(rand64());
        wait_idle();

        // Zero exponent: result is 1.
        set_key('0, rand64() | 64'h8000_0000_0000_0001);
        add_base('0);
        add_base('1);
        add_base(rand64());
        wait_idle();

        // Modulus of one: always 0, including with a zero exponent.
        set_key(rand64(), DATA_W'(1));
        add_base(rand64());
        add_base('1);
        wait_idle();
        set_key('0, DATA_W'(1));
        add_base(rand64());
        wait_idle();

        // Modulus of zero: fast answer of 0.
        set_key(rand64(), '0);
        add_base('0);
        add_base('1);
        add_base(rand64());
        wait_idle();

        // Exponent one: result is the reduced base; bases straddle the modulus.
        m_pick = {1'b1, 63'(rand64())};
        set_key(DATA_W'(1), m_pick);
        add_base(m_pick - DATA_W'(1));
        add_base(m_pick);
        add_base(m_pick + DATA_W'(1));
        add_base('1);
        wait_idle();

        // Random part: a fresh key per group.
        for (int g = 0; g < NUM_GROUPS; g++) begin
            if (g == 4) begin
                send_idle_pct = 52;
                recv_idle_pct = 30;
            end else if (g == 7) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            set_key(pick_exponent(), pick_modulus());
            // back-pressure run: receiver stops for a long stretch, input stalls
            if (g == 7)
                pressure_go = 1'b1;
            for (int k = 0; k < GROUP_SIZE; k++)
                add_base(pick_base());
            wait_idle();
        end

        repeat (END_SETTLE) @(posedge i_clk);
        if (expected_powers.size() != 0)
            report_mismatch("results still owed at end", '0, '0);

        $display("Covered %0d bases and %0d checked results over %0d key writes, %0d cycles.",
                 bases_sent, results_checked, key_writes, cycle_count);
        $display("Included zero, unit and full-range moduli and exponents plus a long stall.");
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches", error_count);
            $display("Verification failed");
        end
        $finish;
    end

endmodule
